// ----- src/erqt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package erqt_pkg;

    localparam logic KIND_BASIS = 1'b0;
    localparam logic KIND_QUAT  = 1'b1;

    localparam logic [1:0] WHICH_FWD   = 2'd0;
    localparam logic [1:0] WHICH_RIGHT = 2'd1;
    localparam logic [1:0] WHICH_UP    = 2'd2;
    localparam logic [1:0] WHICH_QUAT  = 2'd3;

    // cordic start magnitude, Q30
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] pitch_deg;
        logic signed [15:0] yaw_deg;
        logic signed [15:0] roll_deg;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         which;
        logic signed [15:0] comp_x;
        logic signed [15:0] comp_y;
        logic signed [15:0] comp_z;
        logic signed [15:0] comp_w;
        logic               last;
    } result_t;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [33:0] z;
        logic               neg;
    } trig_t;

    // angle lanes: 0 pitch, 1 yaw, 2 roll
    typedef struct packed {
        logic              valid;
        logic              kind;
        trig_t [2:0]       ang;
    } cell_bus_t;

    function automatic logic [31:0] atan_turns(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // inverse of 45 modulo 2^32 by newton steps
    function automatic logic [31:0] inv45();
        logic [31:0] x;
        x = 32'd1;
        for (int i = 0; i < 6; i++) begin
            x = x * (32'd2 - 32'd45 * x);
        end
        return x;
    endfunction

    // q30 product rounded back to q30
    function automatic logic signed [34:0] qmul(input logic signed [34:0] a,
                                                input logic signed [34:0] b);
        logic signed [69:0] p;
        p = 70'(a) * 70'(b) + 70'sd536870912;
        return 35'(p >>> 30);
    endfunction

endpackage

`default_nettype wire

// ----- src/erqt_phase.sv -----
`timescale 1ns / 1ps
`default_nettype none

module erqt_phase #(
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  wire logic               clk,
    input  wire logic signed [15:0] angle,
    input  wire logic               half,
    output erqt_pkg::trig_t         trig
);

    localparam int SF      = ANGLE_FRAC_BITS + 3;
    localparam int SH_FULL = 32 - SF;
    localparam int SH_HALF = 31 - SF;
    localparam logic [5:0] P_FULL = 6'((64'd1 << SH_FULL) % 64'd45);
    localparam logic [5:0] P_HALF = 6'((64'd1 << SH_HALF) % 64'd45);
    localparam logic [17:0] RCP_U = 18'd186414;
    localparam logic [11:0] RCP_T = 12'd2913;
    localparam logic [31:0] INV45 = erqt_pkg::inv45();

    logic [16:0] u;
    logic [34:0] prod1;
    logic [31:0] ext;
    logic [31:0] ash;
    logic [5:0]  r45;
    logic [5:0]  pmod;
    logic [22:0] prod2;
    logic [5:0]  q2;
    logic [5:0]  rem;
    logic signed [33:0] z0;

    logic [16:0] u_reg;
    logic [10:0] q1_reg;
    logic [31:0] ash_reg;
    logic        half_reg;
    logic [10:0] t_reg;
    logic [31:0] xb_reg;
    logic [31:0] xq_reg;
    logic [31:0] phase_reg;
    erqt_pkg::trig_t trig_reg;
    erqt_pkg::trig_t trig_next;

    // angle + 32805, a multiple of 45 that keeps the value positive
    assign u     = {~angle[15], angle[14:0]} + 17'd37;
    assign prod1 = 35'(u) * 35'(RCP_U);
    assign ext   = 32'(angle);
    assign ash   = half ? (ext << SH_HALF) : (ext << SH_FULL);

    assign r45   = 6'(u_reg - 17'(q1_reg) * 17'd45);
    assign pmod  = half_reg ? P_HALF : P_FULL;

    assign prod2 = 23'(t_reg) * 23'(RCP_T);
    assign q2    = 6'(prod2 >> 17);
    assign rem   = 6'(t_reg - 11'(q2) * 11'd45);

    always_comb
    begin
        z0 = 34'($signed(phase_reg));
        trig_next.x   = erqt_pkg::CORDIC_GAIN;
        trig_next.y   = '0;
        trig_next.neg = 1'b0;
        trig_next.z   = z0;
        if (z0 > 34'sd1073741824)
        begin
            trig_next.z   = z0 - 34'sd2147483648;
            trig_next.neg = 1'b1;
        end
        else if (z0 < -34'sd1073741824)
        begin
            trig_next.z   = z0 + 34'sd2147483648;
            trig_next.neg = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg     <= u;
        q1_reg    <= 11'(prod1 >> 23);
        ash_reg   <= ash;
        half_reg  <= half;
        t_reg     <= 11'(11'(r45) * 11'(pmod) + 11'd22);
        xb_reg    <= ash_reg + 32'd22;
        xq_reg    <= xb_reg - 32'(rem);
        phase_reg <= xq_reg * INV45;
        trig_reg  <= trig_next;
    end

    assign trig = trig_reg;

endmodule

`default_nettype wire

// ----- src/erqt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module erqt_cell #(
    parameter int IDX = 0
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire erqt_pkg::cell_bus_t bus_in,
    output erqt_pkg::cell_bus_t      bus_out
);

    localparam logic signed [33:0] ATAN = 34'($signed({2'b00, erqt_pkg::atan_turns(IDX)}));

    logic                valid_reg;
    logic                kind_reg;
    erqt_pkg::trig_t [2:0] ang_reg;
    erqt_pkg::trig_t [2:0] ang_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ang_next[k].neg = bus_in.ang[k].neg;
            if (!bus_in.ang[k].z[33])
            begin
                ang_next[k].x = bus_in.ang[k].x - (bus_in.ang[k].y >>> IDX);
                ang_next[k].y = bus_in.ang[k].y + (bus_in.ang[k].x >>> IDX);
                ang_next[k].z = bus_in.ang[k].z - ATAN;
            end
            else
            begin
                ang_next[k].x = bus_in.ang[k].x + (bus_in.ang[k].y >>> IDX);
                ang_next[k].y = bus_in.ang[k].y - (bus_in.ang[k].x >>> IDX);
                ang_next[k].z = bus_in.ang[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= bus_in.valid;
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= bus_in.kind;
        ang_reg  <= ang_next;
    end

    assign bus_out.valid = valid_reg;
    assign bus_out.kind  = kind_reg;
    assign bus_out.ang   = ang_reg;

endmodule

`default_nettype wire

// ----- src/erqt_mix.sv -----
`timescale 1ns / 1ps
`default_nettype none

module erqt_mix #(
    parameter int OUT_FRAC_BITS = 15
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire erqt_pkg::cell_bus_t bus_in,
    output logic                     done,
    output erqt_pkg::result_t        result
);

    localparam int SH  = 30 - OUT_FRAC_BITS;
    localparam int SH1 = (SH > 0) ? SH - 1 : 0;
    localparam logic signed [36:0] RND = (SH > 0) ? (37'sd1 <<< SH1) : 37'sd0;
    localparam longint HI_RAW = (64'sd1 <<< OUT_FRAC_BITS) - 64'sd1;
    localparam longint LO_RAW = -(64'sd1 <<< OUT_FRAC_BITS);
    localparam longint HI = (HI_RAW > 64'sd32767) ? 64'sd32767 : HI_RAW;
    localparam longint LO = (LO_RAW < -64'sd32768) ? -64'sd32768 : LO_RAW;

    function automatic logic signed [15:0] sat(input logic signed [36:0] v);
        logic signed [36:0] r;
        logic signed [63:0] w;
        r = (v + RND) >>> SH;
        w = 64'(r);
        if (w > HI)
            w = HI;
        if (w < LO)
            w = LO;
        return 16'(w);
    endfunction

    logic signed [34:0] sp, cp, sy, cy, sr, cr;

    // first product level
    logic               v1_reg, k1_reg;
    logic signed [34:0] cpcy_reg, cpsy_reg, srsp_reg, crsp_reg, crsy_reg;
    logic signed [34:0] crcy_reg, srsy_reg, srcy_reg, srcp_reg, crcp_reg;
    logic signed [34:0] sp1_reg, sy1_reg, cy1_reg;

    // second product level
    logic               v2_reg, k2_reg;
    logic signed [34:0] srspcy_reg, srspsy_reg, crspcy_reg, crspsy_reg;
    logic signed [34:0] srcpcy_reg, srcpsy_reg, crcpcy_reg, crcpsy_reg;
    logic signed [34:0] cpcy2_reg, cpsy2_reg, crsy2_reg, crcy2_reg, srsy2_reg;
    logic signed [34:0] srcy2_reg, srcp2_reg, crcp2_reg, sp2_reg;

    logic               v3_reg, k3_reg;
    erqt_pkg::result_t  r0_reg, r1_reg, r2_reg;
    erqt_pkg::result_t  r0_next, r1_next, r2_next;

    logic               done_reg;
    logic [1:0]         cnt_reg;
    erqt_pkg::result_t  out_reg, hold1_reg, hold2_reg;

    always_comb
    begin
        sp = 35'(bus_in.ang[0].neg ? -bus_in.ang[0].y : bus_in.ang[0].y);
        cp = 35'(bus_in.ang[0].neg ? -bus_in.ang[0].x : bus_in.ang[0].x);
        sy = 35'(bus_in.ang[1].neg ? -bus_in.ang[1].y : bus_in.ang[1].y);
        cy = 35'(bus_in.ang[1].neg ? -bus_in.ang[1].x : bus_in.ang[1].x);
        sr = 35'(bus_in.ang[2].neg ? -bus_in.ang[2].y : bus_in.ang[2].y);
        cr = 35'(bus_in.ang[2].neg ? -bus_in.ang[2].x : bus_in.ang[2].x);
    end

    always_comb
    begin
        r0_next = '0;
        r1_next = '0;
        r2_next = '0;
        if (k2_reg == erqt_pkg::KIND_QUAT)
        begin
            r0_next.which  = erqt_pkg::WHICH_QUAT;
            r0_next.comp_x = sat(37'(srcpcy_reg) - 37'(crspsy_reg));
            r0_next.comp_y = sat(37'(crspcy_reg) + 37'(srcpsy_reg));
            r0_next.comp_z = sat(37'(crcpsy_reg) - 37'(srspcy_reg));
            r0_next.comp_w = sat(37'(crcpcy_reg) + 37'(srspsy_reg));
            r0_next.last   = 1'b1;
        end
        else
        begin
            r0_next.which  = erqt_pkg::WHICH_FWD;
            r0_next.comp_x = sat(37'(cpcy2_reg));
            r0_next.comp_y = sat(37'(cpsy2_reg));
            r0_next.comp_z = sat(-37'(sp2_reg));
            r1_next.which  = erqt_pkg::WHICH_RIGHT;
            r1_next.comp_x = sat(37'(srspcy_reg) - 37'(crsy2_reg));
            r1_next.comp_y = sat(37'(crcy2_reg) + 37'(srspsy_reg));
            r1_next.comp_z = sat(37'(srcp2_reg));
            r2_next.which  = erqt_pkg::WHICH_UP;
            r2_next.comp_x = sat(37'(crspcy_reg) + 37'(srsy2_reg));
            r2_next.comp_y = sat(37'(crspsy_reg) - 37'(srcy2_reg));
            r2_next.comp_z = sat(37'(crcp2_reg));
            r2_next.last   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            v1_reg <= bus_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (v3_reg)
            begin
                done_reg <= 1'b1;
                cnt_reg  <= (k3_reg == erqt_pkg::KIND_QUAT) ? 2'd0 : 2'd2;
            end
            else if (cnt_reg != 2'd0)
            begin
                done_reg <= 1'b1;
                cnt_reg  <= cnt_reg - 2'd1;
            end
            else
                done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        k1_reg   <= bus_in.kind;
        cpcy_reg <= erqt_pkg::qmul(cp, cy);
        cpsy_reg <= erqt_pkg::qmul(cp, sy);
        srsp_reg <= erqt_pkg::qmul(sr, sp);
        crsp_reg <= erqt_pkg::qmul(cr, sp);
        crsy_reg <= erqt_pkg::qmul(cr, sy);
        crcy_reg <= erqt_pkg::qmul(cr, cy);
        srsy_reg <= erqt_pkg::qmul(sr, sy);
        srcy_reg <= erqt_pkg::qmul(sr, cy);
        srcp_reg <= erqt_pkg::qmul(sr, cp);
        crcp_reg <= erqt_pkg::qmul(cr, cp);
        sp1_reg  <= sp;
        sy1_reg  <= sy;
        cy1_reg  <= cy;

        k2_reg     <= k1_reg;
        srspcy_reg <= erqt_pkg::qmul(srsp_reg, cy1_reg);
        srspsy_reg <= erqt_pkg::qmul(srsp_reg, sy1_reg);
        crspcy_reg <= erqt_pkg::qmul(crsp_reg, cy1_reg);
        crspsy_reg <= erqt_pkg::qmul(crsp_reg, sy1_reg);
        srcpcy_reg <= erqt_pkg::qmul(srcp_reg, cy1_reg);
        srcpsy_reg <= erqt_pkg::qmul(srcp_reg, sy1_reg);
        crcpcy_reg <= erqt_pkg::qmul(crcp_reg, cy1_reg);
        crcpsy_reg <= erqt_pkg::qmul(crcp_reg, sy1_reg);
        cpcy2_reg  <= cpcy_reg;
        cpsy2_reg  <= cpsy_reg;
        crsy2_reg  <= crsy_reg;
        crcy2_reg  <= crcy_reg;
        srsy2_reg  <= srsy_reg;
        srcy2_reg  <= srcy_reg;
        srcp2_reg  <= srcp_reg;
        crcp2_reg  <= crcp_reg;
        sp2_reg    <= sp1_reg;

        k3_reg <= k2_reg;
        r0_reg <= r0_next;
        r1_reg <= r1_next;
        r2_reg <= r2_next;

        // basis runs drain right and up from the hold stages
        if (v3_reg)
        begin
            out_reg   <= r0_reg;
            hold1_reg <= r1_reg;
            hold2_reg <= r2_reg;
        end
        else if (cnt_reg != 2'd0)
        begin
            out_reg   <= hold1_reg;
            hold1_reg <= hold2_reg;
        end
    end

    assign done   = done_reg;
    assign result = out_reg;

endmodule

`default_nettype wire

// ----- src/euler_to_rotation_basis_and_quat_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// euler angles to basis vectors or quaternion. an item is taken when start is
// high and busy low; its first result appears with done high after the phase
// stages, the cordic cells and the mix stages. a basis item (kind 0) gives
// forward, right and up on consecutive cycles and holds busy high after it is
// taken, so the next item waits; quaternion items go in every cycle while busy
// is low. the single result port, one result per cycle, sets that rate.
// results cannot be stalled: done is high for exactly one cycle per result.
module euler_to_rotation_basis_and_quat_unit #(
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int OUT_FRAC_BITS   = 15,
    parameter int TRIG_STAGES     = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire erqt_pkg::cmd_t cmd,
    output logic                done,
    output erqt_pkg::result_t   result
);

    localparam int PHASE_DEPTH = 5;

    logic                   accept;
    logic [1:0]             hold_reg;
    logic [1:0]             hold_next;
    logic [PHASE_DEPTH-1:0] vpipe_reg;
    logic [PHASE_DEPTH-1:0] kpipe_reg;
    erqt_pkg::trig_t [2:0]  ang0;
    erqt_pkg::cell_bus_t    chain [0:TRIG_STAGES];

    assign accept = start && !busy;
    assign busy   = (hold_reg != 2'd0);

    always_comb
    begin
        hold_next = hold_reg;
        if (accept && cmd.kind == erqt_pkg::KIND_BASIS)
            hold_next = 2'd2;
        else if (hold_reg != 2'd0)
            hold_next = hold_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg  <= 2'd0;
            vpipe_reg <= '0;
        end
        else
        begin
            hold_reg  <= hold_next;
            vpipe_reg <= {vpipe_reg[PHASE_DEPTH-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        kpipe_reg <= {kpipe_reg[PHASE_DEPTH-2:0], cmd.kind};
    end

    erqt_phase #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_phase_pitch (
        .clk   (clk),
        .angle (cmd.pitch_deg),
        .half  (cmd.kind),
        .trig  (ang0[0])
    );

    erqt_phase #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_phase_yaw (
        .clk   (clk),
        .angle (cmd.yaw_deg),
        .half  (cmd.kind),
        .trig  (ang0[1])
    );

    erqt_phase #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_phase_roll (
        .clk   (clk),
        .angle (cmd.roll_deg),
        .half  (cmd.kind),
        .trig  (ang0[2])
    );

    assign chain[0].valid = vpipe_reg[PHASE_DEPTH-1];
    assign chain[0].kind  = kpipe_reg[PHASE_DEPTH-1];
    assign chain[0].ang   = ang0;

    for (genvar i = 0; i < TRIG_STAGES; i++)
    begin : g_cell
        erqt_cell #(.IDX(i)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bus_in  (chain[i]),
            .bus_out (chain[i+1])
        );
    end

    erqt_mix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mix (
        .clk    (clk),
        .rst_n  (rst_n),
        .bus_in (chain[TRIG_STAGES]),
        .done   (done),
        .result (result)
    );

    a_basis_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.kind == erqt_pkg::KIND_BASIS) |=> busy ##1 busy)
        else $error("basis item did not hold off the next item");

    a_fwd_then_right: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.which == erqt_pkg::WHICH_FWD) |=>
        (done && result.which == erqt_pkg::WHICH_RIGHT))
        else $error("forward not followed by right");

    a_right_then_up: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.which == erqt_pkg::WHICH_RIGHT) |=>
        (done && result.which == erqt_pkg::WHICH_UP && result.last))
        else $error("right not followed by last up");

    a_basis_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.which != erqt_pkg::WHICH_QUAT) |-> (result.comp_w == 16'sd0))
        else $error("basis vector with nonzero w");

endmodule

`default_nettype wire
